>>> hw/rtl/bsfr_pkg.sv
// ----------------------------------------------------------------------------
// bsfr_pkg: shared types for the byte stream find-and-replace block
// Payload structs for the request and response channels, configuration
// register indexes and the sequencer state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package bsfr_pkg;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_BYTES      = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LENGTH     = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPLACEMENT_BYTES  = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPLACEMENT_LENGTH = 4'd3;

   localparam int unsigned CSR_DATA_W = 64;
   localparam int unsigned LEN_W      = 4;

   // Source byte transfer
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   // Output stream transfer
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_present;
      logic       end_of_stream;
   } rsp_type;

   // Sequencer states, one-hot
   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_CHECK   = 6'b000010,
      ST_RELEASE = 6'b000100,
      ST_REPLACE = 6'b001000,
      ST_PASS    = 6'b010000,
      ST_MARK    = 6'b100000
   } state_type;

endpackage

`default_nettype wire

>>> hw/rtl/byte_stream_find_replace.sv
// ----------------------------------------------------------------------------
// byte_stream_find_replace: streaming substring replace
// Holds source bytes that may begin a pattern match, swaps each leftmost
// non-overlapping match for the replacement and releases all other bytes.
// ----------------------------------------------------------------------------
// Path: a pass-through byte goes via pass_byte_ff to the response register; a
//   held byte is checked in ST_CHECK before ST_RELEASE or ST_REPLACE loads the
//   response register while it is free. A new source byte is taken only in
//   ST_IDLE, once all output of the last one is sent; the single prefix
//   comparator and hold shifter are shared across those steps.
// Reset: synchronous, on the control state only; the pattern length resets to 1.
`default_nettype none

module byte_stream_find_replace
   import bsfr_pkg::*;
#(
   parameter int MAX_PATTERN     = 8,
   parameter int MAX_REPLACEMENT = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Request channel
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire req_type                req_data,
   // Response channel
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rsp_type                     rsp_data,
   // Configuration write channel
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int CNT_W  = $clog2(MAX_PATTERN + 1);
   localparam int PIDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int RCNT_W = $clog2(MAX_REPLACEMENT + 1);
   localparam int RIDX_W = (MAX_REPLACEMENT > 1) ? $clog2(MAX_REPLACEMENT) : 1;

   // Registers
   state_type             state_ff, state_in;
   logic [CSR_DATA_W-1:0] pattern_bytes_ff, pattern_bytes_in;
   logic [LEN_W-1:0]      pattern_length_ff, pattern_length_in;
   logic [CSR_DATA_W-1:0] replacement_bytes_ff, replacement_bytes_in;
   logic [LEN_W-1:0]      replacement_length_ff, replacement_length_in;
   logic [7:0]            hold_buffer_ff [MAX_PATTERN];
   logic [7:0]            hold_buffer_in [MAX_PATTERN];
   logic [CNT_W-1:0]      hold_count_ff, hold_count_in;
   logic [RIDX_W-1:0]     repl_idx_ff, repl_idx_in;
   logic [7:0]            pass_byte_ff, pass_byte_in;
   logic                  last_ff, last_in;
   logic                  emitted_ff, emitted_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   // Combinational helpers
   logic                  req_take;
   logic                  csr_take;
   logic                  out_free;
   logic [CNT_W-1:0]      pl_eff;
   logic [RCNT_W-1:0]     rl_eff;
   logic [CNT_W-1:0]      append_base;
   logic [MAX_PATTERN-1:0] lane_miss;
   logic                  prefix_ok;
   logic                  repl_final;

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_take  = csr_valid && csr_ready;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Saturate the configured lengths
   assign pl_eff = (pattern_length_ff > LEN_W'(MAX_PATTERN)) ?
                   CNT_W'(MAX_PATTERN) : CNT_W'(pattern_length_ff);
   assign rl_eff = (replacement_length_ff > LEN_W'(MAX_REPLACEMENT)) ?
                   RCNT_W'(MAX_REPLACEMENT) : RCNT_W'(replacement_length_ff);

   assign append_base = (hold_count_ff >= pl_eff) ? '0 : hold_count_ff;
   assign repl_final  = ((RCNT_W'(repl_idx_ff) + RCNT_W'(1)) == rl_eff);

   // Shared prefix comparator over the held bytes
   always_comb begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
         lane_miss[i] = (CNT_W'(i) < hold_count_ff) &&
                        (hold_buffer_ff[i] != pattern_bytes_ff[8*i +: 8]);
      end
   end
   assign prefix_ok = ~|lane_miss;

   // Sequencer, hold buffer and response register
   always_comb begin
      state_in              = state_ff;
      pattern_bytes_in      = pattern_bytes_ff;
      pattern_length_in     = pattern_length_ff;
      replacement_bytes_in  = replacement_bytes_ff;
      replacement_length_in = replacement_length_ff;
      hold_buffer_in        = hold_buffer_ff;
      hold_count_in         = hold_count_ff;
      repl_idx_in           = repl_idx_ff;
      pass_byte_in          = pass_byte_ff;
      last_in               = last_ff;
      emitted_in            = emitted_ff;
      rsp_valid_in          = rsp_valid_ff && rsp_stall;
      rsp_data_in           = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               last_in    = req_data.last_byte;
               emitted_in = 1'b0;
               if (pl_eff == '0) begin
                  // matching off: send the byte straight on
                  pass_byte_in  = req_data.data_byte;
                  hold_count_in = '0;
                  state_in      = ST_PASS;
               end else begin
                  hold_buffer_in[append_base[PIDX_W-1:0]] = req_data.data_byte;
                  hold_count_in = append_base + CNT_W'(1);
                  state_in      = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            priority if ((hold_count_ff == pl_eff) && prefix_ok) begin
               // full match: drop the held bytes, send the replacement
               hold_count_in = '0;
               repl_idx_in   = '0;
               if (rl_eff != '0) begin
                  state_in = ST_REPLACE;
               end else if (last_ff && !emitted_ff) begin
                  state_in = ST_MARK;
               end else begin
                  state_in = ST_IDLE;
               end
            end else if ((hold_count_ff != '0) && (!prefix_ok || last_ff)) begin
               state_in = ST_RELEASE;
            end else if (last_ff && !emitted_ff) begin
               state_in = ST_MARK;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_RELEASE: begin
            if (out_free) begin
               // release the front byte and shift the rest down
               rsp_valid_in              = 1'b1;
               rsp_data_in.out_byte      = hold_buffer_ff[0];
               rsp_data_in.byte_present  = 1'b1;
               rsp_data_in.end_of_stream = last_ff && (hold_count_ff == CNT_W'(1));
               for (int i = 0; i < MAX_PATTERN - 1; i++) begin
                  hold_buffer_in[i] = hold_buffer_ff[i+1];
               end
               hold_count_in = hold_count_ff - CNT_W'(1);
               emitted_in    = 1'b1;
               state_in      = ST_CHECK;
            end
         end
         ST_REPLACE: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.out_byte      = replacement_bytes_ff[{repl_idx_ff, 3'b000} +: 8];
               rsp_data_in.byte_present  = 1'b1;
               rsp_data_in.end_of_stream = last_ff && repl_final;
               emitted_in                = 1'b1;
               if (repl_final) begin
                  state_in = ST_IDLE;
               end else begin
                  repl_idx_in = repl_idx_ff + RIDX_W'(1);
               end
            end
         end
         ST_PASS: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.out_byte      = pass_byte_ff;
               rsp_data_in.byte_present  = 1'b1;
               rsp_data_in.end_of_stream = last_ff;
               emitted_in                = 1'b1;
               state_in                  = ST_IDLE;
            end
         end
         ST_MARK: begin
            if (out_free) begin
               // bare end marker
               rsp_valid_in              = 1'b1;
               rsp_data_in.out_byte      = 8'd0;
               rsp_data_in.byte_present  = 1'b0;
               rsp_data_in.end_of_stream = 1'b1;
               emitted_in                = 1'b1;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Configuration transfer to a known index: update the register and drop held bytes
      if (csr_take) begin
         unique case (csr_index)
            CSR_PATTERN_BYTES: begin
               pattern_bytes_in = csr_data;
               hold_count_in    = '0;
            end
            CSR_PATTERN_LENGTH: begin
               pattern_length_in = csr_data[LEN_W-1:0];
               hold_count_in     = '0;
            end
            CSR_REPLACEMENT_BYTES: begin
               replacement_bytes_in = csr_data;
               hold_count_in        = '0;
            end
            CSR_REPLACEMENT_LENGTH: begin
               replacement_length_in = csr_data[LEN_W-1:0];
               hold_count_in         = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff              <= ST_IDLE;
         pattern_bytes_ff      <= '0;
         pattern_length_ff     <= LEN_W'(1);
         replacement_bytes_ff  <= '0;
         replacement_length_ff <= '0;
         hold_count_ff         <= '0;
         last_ff               <= 1'b0;
         emitted_ff            <= 1'b0;
         rsp_valid_ff          <= 1'b0;
      end else begin
         state_ff              <= state_in;
         pattern_bytes_ff      <= pattern_bytes_in;
         pattern_length_ff     <= pattern_length_in;
         replacement_bytes_ff  <= replacement_bytes_in;
         replacement_length_ff <= replacement_length_in;
         hold_count_ff         <= hold_count_in;
         last_ff               <= last_in;
         emitted_ff            <= emitted_in;
         rsp_valid_ff          <= rsp_valid_in;
      end
   end

   // Payload state
   always_ff @(posedge clock) begin
      hold_buffer_ff <= hold_buffer_in;
      repl_idx_ff    <= repl_idx_in;
      pass_byte_ff   <= pass_byte_in;
      rsp_data_ff    <= rsp_data_in;
   end

`ifndef NO_ASSERTIONS
   // Held bytes never reach past the effective pattern length
   a_hold_bounded: assert property (@(posedge clock) disable iff (reset)
      hold_count_ff <= pl_eff)
      else $error("hold count exceeds pattern length");

   // A bare response is always the end marker
   a_bare_is_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.byte_present |-> rsp_data_ff.end_of_stream)
      else $error("bare response without end of stream");

   // Replacement bytes go out only after the held match was dropped
   a_replace_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_REPLACE |-> hold_count_ff == '0)
      else $error("bytes held while sending replacement");

   // Once the last byte is processed nothing is held
   a_flushed: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE && last_ff |-> hold_count_ff == '0)
      else $error("bytes held after end of stream");
`endif

endmodule

`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: byte stream find-and-replace testbench
// Streams source bytes into the block and compares every output transfer with
// a cycle-free predictor of the substring replace. The predictor keeps its own
// copy of the pattern, replacement and held bytes. Directed streams cover the
// reset settings, prefix release, flush, bare end marker, length saturation
// and configuration writes. Random streams follow under three idling phases,
// plus one long receiver hold-off.
// ----------------------------------------------------------------------------

module tb;
   import bsfr_pkg::*;

   localparam int MAX_PATTERN     = 8;
   localparam int MAX_REPLACEMENT = 8;
   localparam int DRAIN_CYCLES    = 40;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 4'hF;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_type                rsp_data;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   // Predictor copy of configuration and hold state
   logic [63:0]      pat_bytes;
   logic [LEN_W-1:0] pat_len;
   logic [63:0]      rep_bytes;
   logic [LEN_W-1:0] rep_len;
   logic [7:0]       held [8];
   logic [3:0]       held_count;

   // Output bytes still to come, oldest first
   rsp_type replaced_stream[$];

   int send_gap_pct;
   int rsp_stall_pct;
   int hold_off_cycles;
   int bytes_offered;
   int mismatch_count;
   int quiet_cycles;

   byte_stream_find_replace dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------
   function automatic bit held_is_prefix(input int unsigned n);
      int unsigned i;
      for (i = 0; i < n && i < 8; i++) begin
         if (held[i] != pat_bytes[8*i +: 8]) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Take the oldest held byte and shift the rest down
   function automatic logic [7:0] pop_held_front();
      logic [7:0] front;
      int i;
      front = held[0];
      for (i = 0; i < 7; i++) held[i] = held[i+1];
      held[7] = 8'h00;
      held_count = held_count - 4'd1;
      return front;
   endfunction

   function automatic void find_replace_step(input req_type item);
      rsp_type     produced[$];
      rsp_type     tail;
      int unsigned eff_pat;
      int unsigned eff_rep;
      int unsigned i;
      eff_pat = (pat_len > MAX_PATTERN) ? MAX_PATTERN : pat_len;
      eff_rep = (rep_len > MAX_REPLACEMENT) ? MAX_REPLACEMENT : rep_len;
      if (eff_pat == 0) begin
         // matching off: pass the byte straight through
         held_count = 4'd0;
         produced.push_back({item.data_byte, 1'b1, 1'b0});
      end else begin
         if (held_count >= eff_pat || held_count >= MAX_PATTERN) held_count = 4'd0;
         held[held_count[2:0]] = item.data_byte;
         held_count = held_count + 4'd1;
         if (held_count == eff_pat && held_is_prefix(eff_pat)) begin
            for (i = 0; i < eff_rep; i++) produced.push_back({rep_bytes[8*i +: 8], 1'b1, 1'b0});
            held_count = 4'd0;
         end else begin
            while (held_count > 0 && !held_is_prefix(held_count))
               produced.push_back({pop_held_front(), 1'b1, 1'b0});
         end
         // flush whatever is held at the end of the source stream
         if (item.last_byte) begin
            while (held_count > 0) produced.push_back({pop_held_front(), 1'b1, 1'b0});
         end
      end
      if (item.last_byte) begin
         if (produced.size() > 0) begin
            tail = produced.pop_back();
            tail.end_of_stream = 1'b1;
            produced.push_back(tail);
         end else begin
            produced.push_back({8'h00, 1'b0, 1'b1});
         end
      end
      foreach (produced[k]) replaced_stream.push_back(produced[k]);
   endfunction

   // ------------------------------------------------------------------------
   // Predict on each request transfer, check each response transfer
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (req_valid && !req_stall) find_replace_step(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (replaced_stream.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected output: expected none, %s %02h present %b end %b",
                        $time, "actual byte", rsp_data.out_byte,
                        rsp_data.byte_present, rsp_data.end_of_stream);
            end else begin
               want = replaced_stream.pop_front();
               if (rsp_data.out_byte != want.out_byte
                   || rsp_data.byte_present != want.byte_present
                   || rsp_data.end_of_stream != want.end_of_stream) begin
                  mismatch_count++;
                  $display({"%0t: output differs: expected byte %02h present %b end %b, ",
                            "actual byte %02h present %b end %b"},
                           $time, want.out_byte, want.byte_present, want.end_of_stream,
                           rsp_data.out_byte, rsp_data.byte_present,
                           rsp_data.end_of_stream);
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   // End the run when nothing has moved for too long
   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Receiver: long hold-off when asked, random stalls otherwise
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_off_cycles = hold_off_cycles - 1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Transfer tasks: all start and end at a falling edge
   // ------------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] value, input logic last);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= {value, last};
      @(posedge clock);
      while (!(req_valid && !req_stall)) @(posedge clock);
      bytes_offered++;
      @(negedge clock);
   endtask

   // Wait until every awaited byte has come, then let the block settle
   task automatic drain_outputs();
      req_valid <= 1'b0;
      @(negedge clock);
      while (replaced_stream.size() > 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!(csr_valid && csr_ready)) @(posedge clock);
      case (index)
         CSR_PATTERN_BYTES:      pat_bytes = value;
         CSR_PATTERN_LENGTH:     pat_len   = value[LEN_W-1:0];
         CSR_REPLACEMENT_BYTES:  rep_bytes = value;
         CSR_REPLACEMENT_LENGTH: rep_len   = value[LEN_W-1:0];
         default: ;
      endcase
      // any known register drops the held bytes
      if (index <= CSR_REPLACEMENT_LENGTH) held_count = 4'd0;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic load_config(input logic [63:0] pattern, input logic [LEN_W-1:0] plen,
                              input logic [63:0] replacement, input logic [LEN_W-1:0] rlen);
      drain_outputs();
      write_csr(CSR_PATTERN_BYTES, pattern);
      write_csr(CSR_PATTERN_LENGTH, CSR_DATA_W'(plen));
      write_csr(CSR_REPLACEMENT_BYTES, replacement);
      write_csr(CSR_REPLACEMENT_LENGTH, CSR_DATA_W'(rlen));
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Reset settings delete every zero byte; a deleted last byte leaves a bare marker
   task automatic test_reset_config();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
   endtask

   // Partial matches released from the front, a match, a flush at the end,
   // then held bytes dropped by a register write
   task automatic test_prefix_release();
      load_config(64'h0000_0000_0043_4241, 4'd3, 64'h0000_0000_0000_7978, 4'd2);
      send_byte(8'h41, 1'b0);
      send_byte(8'h42, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(8'h42, 1'b0);
      send_byte(8'h43, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(8'h42, 1'b1);
      send_byte(8'h41, 1'b0);
      send_byte(8'h42, 1'b0);
      drain_outputs();
      write_csr(CSR_REPLACEMENT_BYTES, 64'h0123_4567_89AB_CDEF);
      send_byte(8'h43, 1'b1);
   endtask

   // Matching off, saturated lengths with all-ones registers, unused index
   task automatic test_length_extremes();
      int i;
      load_config(64'h0000_0000_0000_0041, 4'd0, 64'h0, 4'd0);
      send_byte(8'h41, 1'b0);
      send_byte(8'h00, 1'b1);
      load_config({64{1'b1}}, 4'hF, {64{1'b1}}, 4'hF);
      for (i = 0; i < MAX_PATTERN; i++) send_byte(8'hFF, i == MAX_PATTERN - 1);
      // a write to an unused index keeps the held byte
      send_byte(8'hFF, 1'b0);
      drain_outputs();
      write_csr(CSR_UNUSED_INDEX, {$urandom, $urandom});
      send_byte(8'h00, 1'b1);
   endtask

   // Receiver holds off while matches with long replacements keep arriving
   task automatic test_output_hold_off();
      int i;
      int saved_gap;
      load_config(64'h0000_0000_0000_A55A, 4'd2, {$urandom, $urandom}, 4'd8);
      saved_gap = send_gap_pct;
      send_gap_pct = 0;
      hold_off_cycles = 150;
      for (i = 0; i < 40; i++) send_byte((i % 2 == 0) ? 8'h5A : 8'hA5, i == 39);
      send_gap_pct = saved_gap;
   endtask

   // One source stream built from pattern copies, prefixes and noise
   task automatic send_random_stream();
      logic [7:0]  stream[$];
      int unsigned eff;
      int unsigned kind;
      int unsigned n;
      int unsigned k;
      eff = (pat_len > MAX_PATTERN) ? MAX_PATTERN : pat_len;
      if (eff == 0) eff = 1;
      repeat ($urandom_range(6, 1)) begin
         kind = $urandom_range(9);
         if (kind < 4) begin
            for (k = 0; k < eff; k++) stream.push_back(pat_bytes[8*k +: 8]);
         end else if (kind < 6) begin
            n = $urandom_range(eff - 1);
            for (k = 0; k < n; k++) stream.push_back(pat_bytes[8*k +: 8]);
         end else if (kind < 9) begin
            k = $urandom_range(eff - 1);
            stream.push_back(pat_bytes[8*k +: 8] ^ {7'd0, $urandom_range(1) == 1});
         end else begin
            stream.push_back(8'($urandom_range(255)));
         end
      end
      if (stream.size() == 0) stream.push_back(8'($urandom_range(255)));
      for (k = 0; k < stream.size(); k++) send_byte(stream[k], k == stream.size() - 1);
   endtask

   // Random settings, then a few streams under each, until the target is met
   task automatic test_random_streams(input int gap_pct, input int stall_pct,
                                      input int target);
      int          start;
      logic [7:0]  base;
      logic [63:0] pattern;
      logic [3:0]  plen;
      logic [3:0]  rlen;
      int          i;
      send_gap_pct  = gap_pct;
      rsp_stall_pct = stall_pct;
      start = bytes_offered;
      while (bytes_offered - start < target) begin
         // mostly a two-letter pattern so that matches and near misses are common
         base = 8'($urandom_range(255));
         for (i = 0; i < 8; i++)
            pattern[8*i +: 8] = ($urandom_range(7) == 0) ? 8'($urandom_range(255))
                                : base ^ {7'd0, $urandom_range(1) == 1};
         case ($urandom_range(19))
            0:       plen = 4'd0;
            1:       plen = 4'($urandom_range(15, 9));
            default: plen = 4'($urandom_range(MAX_PATTERN, 1));
         endcase
         rlen = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 9))
                                         : 4'($urandom_range(MAX_REPLACEMENT));
         load_config(pattern, plen, {$urandom, $urandom}, rlen);
         repeat ($urandom_range(4, 2)) send_random_stream();
      end
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_data        = '0;
      csr_valid       = 1'b0;
      csr_index       = '0;
      csr_data        = '0;
      pat_bytes       = 64'h0;
      pat_len         = 4'd1;
      rep_bytes       = 64'h0;
      rep_len         = 4'd0;
      held_count      = 4'd0;
      foreach (held[k]) held[k] = 8'h00;
      send_gap_pct    = 36;
      rsp_stall_pct   = 58;
      hold_off_cycles = 0;
      bytes_offered   = 0;
      mismatch_count  = 0;
      quiet_cycles    = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_config();
      test_prefix_release();
      test_length_extremes();
      test_output_hold_off();
      test_random_streams(36, 58, 90);
      test_random_streams(58, 36, 90);
      test_random_streams(0, 0, 90);
      drain_outputs();

      if (mismatch_count == 0 && replaced_stream.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
